// ===== rtl/opaf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opaf_pkg
// Shared types and constants for the one-pole audio filter: mode and
// register codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package opaf_pkg;

    // Sample and configuration widths
    localparam int SAMPLE_W   = 8;
    localparam int BAND_W     = SAMPLE_W + 1;
    localparam int DIFF_W     = 10;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Saturation limits of the output sample
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 8'sh7F;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 8'sh80;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_HIGH = 2'd2;

    // Filter mode codes (the remaining codes behave as passthrough)
    localparam logic [MODE_W-1:0] MODE_PASS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOW   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIGH  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BAND  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NOTCH = 3'd4;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LP_MUL,
        ST_LP_FIN,
        ST_HP_MUL,
        ST_HP_FIN,
        ST_OUT
    } t_state;

    // Source of the output sample
    typedef enum logic [1:0] {
        Y_RAW,
        Y_LP,
        Y_HP,
        Y_BAND
    } t_ysel;

    // Controller to datapath commands
    typedef struct packed {
        logic  load_x;
        logic  mul_en;
        logic  mul_hp;
        logic  hp_from_lp;
        logic  lp_fin;
        logic  hp_fin;
        logic  out_load;
        logic  state_upd;
        t_ysel y_sel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              out_free;
    } t_status;

endpackage

// ===== rtl/opaf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opaf_ctrl
// Sequencer for the filter: takes one sample, steps the shared multiplier
// and scaler through the lowpass and highpass stages the mode needs, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module opaf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  opaf_pkg::t_status i_status,
    output opaf_pkg::t_cmd    o_cmd
);
    import opaf_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.y_sel = Y_RAW;

        case (r_state)
            ST_IDLE: begin
                // Hold off the input while reset is asserted
                o_s_tready = i_rst_n;
                if (i_s_tvalid) begin
                    o_cmd.load_x = 1'b1;
                    case (i_status.mode)
                        MODE_LOW, MODE_BAND, MODE_NOTCH: n_state = ST_LP_MUL;
                        MODE_HIGH:                       n_state = ST_HP_MUL;
                        MODE_PASS:                       n_state = ST_OUT;
                        default:                         n_state = ST_OUT;
                    endcase
                end
            end

            ST_LP_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_LP_FIN;
            end

            ST_LP_FIN: begin
                o_cmd.lp_fin = 1'b1;
                n_state      = (i_status.mode == MODE_LOW) ? ST_OUT : ST_HP_MUL;
            end

            ST_HP_MUL: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_hp     = 1'b1;
                o_cmd.hp_from_lp = (i_status.mode == MODE_NOTCH);
                n_state          = ST_HP_FIN;
            end

            ST_HP_FIN: begin
                o_cmd.hp_fin = 1'b1;
                n_state      = ST_OUT;
            end

            ST_OUT: begin
                // Pick the result and the history update for the mode
                case (i_status.mode)
                    MODE_LOW: begin
                        o_cmd.y_sel     = Y_LP;
                        o_cmd.state_upd = i_status.out_free;
                    end
                    MODE_HIGH, MODE_NOTCH: begin
                        o_cmd.y_sel     = Y_HP;
                        o_cmd.state_upd = i_status.out_free;
                    end
                    MODE_BAND: begin
                        o_cmd.y_sel     = Y_BAND;
                        o_cmd.state_upd = i_status.out_free;
                    end
                    default: begin
                        o_cmd.y_sel     = Y_RAW;
                    end
                endcase
                // Hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/opaf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opaf_datapath
// Configuration registers, filter history, one shared coefficient
// multiplier, the truncate-and-saturate scaler and the output register.
// ----------------------------------------------------------------------------
module opaf_datapath #(
    parameter int COEFF_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [opaf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [opaf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [opaf_pkg::SAMPLE_W-1:0]  i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic signed [opaf_pkg::SAMPLE_W-1:0]  o_m_tdata,
    input  opaf_pkg::t_cmd                        i_cmd,
    output opaf_pkg::t_status                     o_status
);
    import opaf_pkg::*;

    localparam int CW     = (COEFF_BITS > CFG_DATA_W) ? COEFF_BITS : CFG_DATA_W;
    localparam int PROD_W = COEFF_BITS + DIFF_W + 1;
    localparam int NUM_W  = PROD_W + 1;
    localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'(127);
    localparam logic signed [NUM_W-1:0] SAT_LO = NUM_W'(-128);

    logic [MODE_W-1:0]            r_mode;
    logic [CFG_DATA_W-1:0]        r_coeff_lo;
    logic [CFG_DATA_W-1:0]        r_coeff_hi;
    logic signed [SAMPLE_W-1:0]   r_x;
    logic signed [SAMPLE_W-1:0]   r_prev_raw;
    logic signed [SAMPLE_W-1:0]   r_prev_out;
    logic signed [SAMPLE_W-1:0]   r_lp;
    logic signed [SAMPLE_W-1:0]   r_hp;
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_out_valid;
    logic signed [SAMPLE_W-1:0]   r_out_data;

    logic [CW-1:0]                w_lo_ext;
    logic [CW-1:0]                w_hi_ext;
    logic [COEFF_BITS-1:0]        w_a_lo;
    logic [COEFF_BITS-1:0]        w_a_hi;
    logic [COEFF_BITS-1:0]        w_mul_a;
    logic signed [SAMPLE_W-1:0]   w_hp_in;
    logic signed [DIFF_W-1:0]     w_diff_lp;
    logic signed [DIFF_W-1:0]     w_diff_hp;
    logic signed [DIFF_W-1:0]     w_mul_d;
    logic signed [PROD_W-1:0]     w_prod;
    logic signed [NUM_W-1:0]      w_num_lp;
    logic signed [NUM_W-1:0]      w_num;
    logic signed [NUM_W-1:0]      w_floor;
    logic                         w_round;
    logic signed [NUM_W-1:0]      w_trunc;
    logic signed [SAMPLE_W-1:0]   w_sat;
    logic signed [BAND_W-1:0]     w_band_sum;
    logic signed [SAMPLE_W-1:0]   w_y;
    logic                         w_out_free;

    // Take writes whenever reset is released
    assign o_cfg_ready = i_rst_n;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_PASS;
            r_coeff_lo <= '0;
            r_coeff_hi <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:       r_mode     <= i_cfg_data[MODE_W-1:0];
                REG_COEFF_LOW:  r_coeff_lo <= i_cfg_data;
                REG_COEFF_HIGH: r_coeff_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Coefficients at COEFF_BITS: zero-extend or keep the low bits
    assign w_lo_ext = CW'(r_coeff_lo);
    assign w_hi_ext = CW'(r_coeff_hi);
    assign w_a_lo   = w_lo_ext[COEFF_BITS-1:0];
    assign w_a_hi   = w_hi_ext[COEFF_BITS-1:0];

    // Multiplier operands: lowpass step x - prev_out, highpass step
    // prev_out + in - prev_raw where in is the lowpass result in notch mode
    assign w_hp_in   = i_cmd.hp_from_lp ? r_lp : r_x;
    assign w_diff_lp = DIFF_W'(r_x) - DIFF_W'(r_prev_out);
    assign w_diff_hp = DIFF_W'(r_prev_out) + DIFF_W'(w_hp_in) - DIFF_W'(r_prev_raw);
    assign w_mul_a   = i_cmd.mul_hp ? w_a_hi : w_a_lo;
    assign w_mul_d   = i_cmd.mul_hp ? w_diff_hp : w_diff_lp;
    assign w_prod    = $signed({1'b0, w_mul_a}) * w_mul_d;

    // Scale by 2^-COEFF_BITS with truncation toward zero, then saturate
    assign w_num_lp = (NUM_W'(r_prev_out) <<< COEFF_BITS) + NUM_W'(r_prod);
    assign w_num    = i_cmd.lp_fin ? w_num_lp : NUM_W'(r_prod);
    assign w_floor  = w_num >>> COEFF_BITS;
    assign w_round  = w_num[NUM_W-1] && (w_num[COEFF_BITS-1:0] != '0);
    assign w_trunc  = w_floor + NUM_W'(w_round);

    always_comb begin
        if (w_trunc > SAT_HI) begin
            w_sat = SAMPLE_MAX;
        end else if (w_trunc < SAT_LO) begin
            w_sat = SAMPLE_MIN;
        end else begin
            w_sat = w_trunc[SAMPLE_W-1:0];
        end
    end

    // Bandpass: floor of the average of lowpass and highpass
    assign w_band_sum = BAND_W'(r_lp) + BAND_W'(r_hp);

    // Output sample selection
    always_comb begin
        case (i_cmd.y_sel)
            Y_RAW:   w_y = r_x;
            Y_LP:    w_y = r_lp;
            Y_HP:    w_y = r_hp;
            Y_BAND:  w_y = w_band_sum[BAND_W-1:1];
            default: w_y = r_x;
        endcase
    end

    // Sample, product and stage result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_s_tdata;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.lp_fin) begin
            r_lp <= w_sat;
        end
        if (i_cmd.hp_fin) begin
            r_hp <= w_sat;
        end
    end

    // Filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= '0;
            r_prev_out <= '0;
        end else if (i_cmd.state_upd) begin
            r_prev_raw <= r_x;
            r_prev_out <= w_y;
        end
    end

    // Output register: load a result, drop it once the transaction completes
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= w_y;
        end
    end

    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;
    assign o_status.mode     = r_mode;
    assign o_status.out_free = w_out_free;

endmodule

// ===== rtl/one_pole_audio_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_pole_audio_filter
// One-pole RC audio filter on signed 8-bit samples: passthrough, lowpass,
// highpass, bandpass or notch, with unsigned Q0.COEFF_BITS coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream (tvalid/tready/tdata), one result per
//   sample leaves on the m_ stream. Mode and coefficients are written on the
//   cfg channel (index 0 mode, 1 lowpass coefficient, 2 highpass
//   coefficient), which is ready whenever reset is released; write it only
//   while the filter idles.
//   One sample is worked on at a time; the single coefficient multiplier and
//   the scaler behind it are used once per filter stage, a multiply step and
//   then a finish step. The mode picks the stages: none in passthrough,
//   lowpass or highpass alone, lowpass then highpass in bandpass or notch;
//   then the output step loads the result into the output register, and
//   the input is ready again the cycle after that load.
//   A stalled receiver holds the result in the output register; the block
//   finishes the next sample and waits with it until the register frees.
//   Reset clears the mode to passthrough, both coefficients and the sample
//   history to zero, and empties the output register.
// ----------------------------------------------------------------------------
module one_pole_audio_filter #(
    parameter int COEFF_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Sample input; tdata: [7:0] sample_in
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic signed [opaf_pkg::SAMPLE_W-1:0]  i_s_tdata,
    // Filtered output; tdata: [7:0] sample_out
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic signed [opaf_pkg::SAMPLE_W-1:0]  o_m_tdata,
    // Configuration write
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [opaf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [opaf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import opaf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    opaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    opaf_datapath #(
        .COEFF_BITS (COEFF_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

    // A taken sample blocks the input until its result is handed over
    a_one_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready
    ) else $error("input taken again while a sample is in work");

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_tvalid || i_m_tready)
    ) else $error("output register loaded while a result is pending");

    // History moves only with a delivered result
    a_history_with_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.state_upd |-> w_cmd.out_load
    ) else $error("filter history updated without an output load");

endmodule
